// ===== hdl/nts_pkg.sv =====
// ============================================================================
// nts_pkg
// Shared types and constants for the nearest-three predecessor selector.
// ============================================================================
`timescale 1ns / 1ps

package nts_pkg;

    // Default geometry of the history window and the coordinates.
    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int COORD_BITS_DEF   = 30;

    // Fixed field widths of the result item.
    localparam int OFF_BITS   = 8;
    localparam int DIST_BITS  = 31;
    localparam int NEAR_COUNT = 3;

    // Result item packing: three offsets, three distances, zero padding.
    localparam int M_FIELD_BITS = NEAR_COUNT * (OFF_BITS + DIST_BITS);
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;
    localparam int M_PAD_BITS   = M_DATA_BITS - M_FIELD_BITS;

    // Search bounds and counter limits.
    localparam logic [OFF_BITS-1:0] MIN_SEARCH       = 8'd3;
    localparam logic [OFF_BITS-1:0] MAX_OFFSET_RESET = 8'd64;
    localparam logic [OFF_BITS-1:0] ATOMS_SAT        = 8'd255;

    // Coordinate axis handled by the distance unit in a given cycle.
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } nts_axis_t;

    // Tag that travels alongside the history word through the distance unit.
    typedef struct packed {
        logic      valid;
        nts_axis_t axis;
    } nts_tag_t;

endpackage

// ===== hdl/nts_ram.sv =====
// ============================================================================
// nts_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
`timescale 1ns / 1ps

module nts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/nts_dist.sv =====
// ============================================================================
// nts_dist
// Shared squared-distance unit. One axis per cycle goes through a subtract,
// a single multiplier and an accumulator; every third product closes one
// candidate's squared Euclidean distance.
// ============================================================================
`timescale 1ns / 1ps

module nts_dist #(
    parameter int COORD_BITS = nts_pkg::COORD_BITS_DEF,
    localparam int HIST_BITS = 3 * COORD_BITS,
    localparam int SQ_BITS   = 2 * COORD_BITS + 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  nts_pkg::nts_tag_t    tag_in,
    input  logic [HIST_BITS-1:0] self_coords,
    input  logic [HIST_BITS-1:0] hist_word,
    output logic                 dist_valid,
    output logic [SQ_BITS-1:0]   sq_dist
);

    localparam int PROD_BITS = 2 * COORD_BITS;

    logic [COORD_BITS-1:0]        self_sel;
    logic [COORD_BITS-1:0]        hist_sel;
    logic signed [COORD_BITS:0]   diff_w;
    logic [COORD_BITS:0]          mag_w;
    logic [PROD_BITS-1:0]         prod_w;
    logic [SQ_BITS-1:0]           sum_w;

    nts_pkg::nts_tag_t            tag1_reg;
    nts_pkg::nts_tag_t            tag2_reg;
    logic [COORD_BITS-1:0]        diff_reg;
    logic [PROD_BITS-1:0]         prod_reg;
    logic [SQ_BITS-1:0]           acc_reg;
    logic [SQ_BITS-1:0]           dist_reg;
    logic                         dist_valid_reg;

    // Pick the coordinate pair for the axis in flight.
    always_comb begin
        unique case (tag_in.axis)
            nts_pkg::AXIS_X: begin
                self_sel = self_coords[COORD_BITS-1:0];
                hist_sel = hist_word[COORD_BITS-1:0];
            end
            nts_pkg::AXIS_Y: begin
                self_sel = self_coords[2*COORD_BITS-1:COORD_BITS];
                hist_sel = hist_word[2*COORD_BITS-1:COORD_BITS];
            end
            default: begin
                self_sel = self_coords[3*COORD_BITS-1:2*COORD_BITS];
                hist_sel = hist_word[3*COORD_BITS-1:2*COORD_BITS];
            end
        endcase
    end

    // Sign-extended difference and its magnitude, which fits in COORD_BITS.
    assign diff_w = $signed({self_sel[COORD_BITS-1], self_sel})
                  - $signed({hist_sel[COORD_BITS-1], hist_sel});
    assign mag_w  = diff_w[COORD_BITS] ? (COORD_BITS+1)'(-diff_w) : diff_w;

    // The shared multiplier squares one axis difference per cycle.
    assign prod_w = diff_reg * diff_reg;
    assign sum_w  = acc_reg + SQ_BITS'(prod_reg);

    // Three register stages: difference, square, accumulate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg       <= '0;
            tag2_reg       <= '0;
            dist_valid_reg <= 1'b0;
        end else begin
            tag1_reg       <= tag_in;
            tag2_reg       <= tag1_reg;
            diff_reg       <= mag_w[COORD_BITS-1:0];
            prod_reg       <= prod_w;
            dist_valid_reg <= tag2_reg.valid && (tag2_reg.axis == nts_pkg::AXIS_Z);
            if (tag2_reg.valid) begin
                if (tag2_reg.axis == nts_pkg::AXIS_X) begin
                    acc_reg <= SQ_BITS'(prod_reg);
                end else begin
                    acc_reg <= sum_w;
                end
                dist_reg <= sum_w;
            end
        end
    end

    assign dist_valid = dist_valid_reg;
    assign sq_dist    = dist_reg;

endmodule

// ===== hdl/nts_sqrt.sv =====
// ============================================================================
// nts_sqrt
// Iterative integer square root, one result bit per cycle, rounded to the
// nearest integer from the final remainder.
// ============================================================================
`timescale 1ns / 1ps

module nts_sqrt #(
    parameter int COORD_BITS = nts_pkg::COORD_BITS_DEF,
    localparam int SQ_BITS   = 2 * COORD_BITS + 2,
    localparam int ROOT_BITS = COORD_BITS + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [SQ_BITS-1:0]   operand,
    output logic                 busy,
    output logic                 done,
    output logic [ROOT_BITS-1:0] result
);

    localparam logic [SQ_BITS-1:0] TOP_PROBE = SQ_BITS'(1) << (SQ_BITS - 2);

    logic [SQ_BITS-1:0]   rem_reg;
    logic [SQ_BITS-1:0]   root_reg;
    logic [SQ_BITS-1:0]   probe_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [ROOT_BITS-1:0] result_reg;

    logic [SQ_BITS-1:0]   trial_w;
    logic                 take_w;
    logic [SQ_BITS-1:0]   rem_next;
    logic [SQ_BITS-1:0]   root_next;

    // One restoring step: try to subtract root plus the probe bit.
    assign trial_w   = root_reg + probe_reg;
    assign take_w    = (rem_reg >= trial_w);
    assign rem_next  = take_w ? (rem_reg - trial_w) : rem_reg;
    assign root_next = take_w ? ((root_reg >> 1) + probe_reg) : (root_reg >> 1);

    // Step while the probe bit is live, then round the result from the final remainder.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && busy_reg && (probe_reg == '0);
            if (start) begin
                rem_reg   <= operand;
                root_reg  <= '0;
                probe_reg <= TOP_PROBE;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                if (probe_reg != '0) begin
                    rem_reg   <= rem_next;
                    root_reg  <= root_next;
                    probe_reg <= probe_reg >> 2;
                end else begin
                    result_reg <= (rem_reg > root_reg) ? ROOT_BITS'(root_reg + SQ_BITS'(1))
                                                       : ROOT_BITS'(root_reg);
                    busy_reg   <= 1'b0;
                end
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hdl/nearest_three_predecessor_select.sv =====
// ============================================================================
// nearest_three_predecessor_select
// Finds the three nearest of the preceding atoms of a segment by squared
// distance and reports their back-offsets and rounded distances.
//
// An atom of index 0 to 2 is written to the history on acceptance and gives no result.
// Any other atom searching L predecessors holds the input until its result
// item is loaded: the single multiplier handles one axis per cycle, then one
// square-root unit produces one bit per cycle for each of the three distances.
// The input is ready again in the same cycle as that item shows, unless an
// earlier result still waits.
// Synchronous active-low reset clears control state and sets max_offset to 64.
// ============================================================================
`timescale 1ns / 1ps

module nearest_three_predecessor_select #(
    parameter int WINDOW_DEPTH = nts_pkg::WINDOW_DEPTH_DEF,
    parameter int COORD_BITS   = nts_pkg::COORD_BITS_DEF,
    localparam int S_DATA_BITS = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [nts_pkg::OFF_BITS-1:0]    cfg_wr_data,   // max_offset
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [S_DATA_BITS-1:0]          s_tdata,       // coord_x, coord_y, coord_z
    input  logic                            s_tuser,       // first_atom
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // near_offset_a, near_offset_b, near_offset_c, near_dist_a, near_dist_b, near_dist_c
    output logic [nts_pkg::M_DATA_BITS-1:0] m_tdata
);

    localparam int OFF_BITS  = nts_pkg::OFF_BITS;
    localparam int DIST_BITS = nts_pkg::DIST_BITS;
    localparam int PTR_BITS  = $clog2(WINDOW_DEPTH);
    localparam int HIST_BITS = 3 * COORD_BITS;
    localparam int SQ_BITS   = 2 * COORD_BITS + 2;
    localparam int ROOT_BITS = COORD_BITS + 1;
    localparam logic [PTR_BITS-1:0] LAST_PTR  = PTR_BITS'(WINDOW_DEPTH - 1);
    localparam logic [OFF_BITS-1:0] DEPTH_CAP = OFF_BITS'(WINDOW_DEPTH);
    localparam logic [1:0]          LAST_ROOT = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_ROOT  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [OFF_BITS-1:0]         max_offset_reg;
    logic [OFF_BITS-1:0]         atoms_seen_reg;
    logic [PTR_BITS-1:0]         wr_pos_reg;
    logic [PTR_BITS-1:0]         rd_ptr_reg;
    logic [HIST_BITS-1:0]        self_reg;
    logic [OFF_BITS-1:0]         limit_reg;
    logic [OFF_BITS-1:0]         cand_reg;
    nts_pkg::nts_axis_t          axis_reg;
    nts_pkg::nts_axis_t          axis_next;
    logic [OFF_BITS-1:0]         ins_off_reg;
    nts_pkg::nts_tag_t           rd_tag_reg;
    logic [SQ_BITS-1:0]          best_dist_reg [nts_pkg::NEAR_COUNT];
    logic [OFF_BITS-1:0]         best_off_reg  [nts_pkg::NEAR_COUNT];
    logic [2:0]                  best_valid_reg;
    logic [1:0]                  root_idx_reg;
    logic                        root_go_reg;
    logic [ROOT_BITS-1:0]        root_reg [nts_pkg::NEAR_COUNT];
    logic                        m_tvalid_reg;
    logic [nts_pkg::M_DATA_BITS-1:0] m_tdata_reg;

    logic                        in_accept;
    logic [OFF_BITS-1:0]         in_idx;
    logic                        in_produce;
    logic [OFF_BITS-1:0]         lim_lo;
    logic [OFF_BITS-1:0]         lim_cap;
    logic [OFF_BITS-1:0]         in_limit;
    logic [PTR_BITS-1:0]         rd_ptr_start;
    logic [PTR_BITS-1:0]         rd_ptr_dec;
    logic [PTR_BITS-1:0]         wr_pos_inc;
    logic                        out_free;
    logic                        load_out;
    logic                        hist_we;
    logic [HIST_BITS-1:0]        hist_wdata;
    logic [HIST_BITS-1:0]        hist_rdata;
    logic                        issue_last;
    logic                        cand_valid;
    logic [SQ_BITS-1:0]          cand_dist;
    logic                        ins_last;
    logic [2:0]                  lt;
    logic                        root_first;
    logic                        root_more;
    logic                        sqrt_busy;
    logic                        sqrt_done;
    logic [ROOT_BITS-1:0]        sqrt_result;

    // Input handshake and per-item search bound.
    assign s_tready   = (state_reg == S_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign in_idx     = s_tuser ? '0 : atoms_seen_reg;
    assign in_produce = (in_idx >= nts_pkg::MIN_SEARCH);
    assign lim_lo     = (max_offset_reg < nts_pkg::MIN_SEARCH) ? nts_pkg::MIN_SEARCH
                                                               : max_offset_reg;
    assign lim_cap    = (lim_lo > DEPTH_CAP) ? DEPTH_CAP : lim_lo;
    assign in_limit   = (lim_cap > in_idx) ? in_idx : lim_cap;

    // Ring pointer arithmetic.
    assign rd_ptr_start = (wr_pos_reg == '0) ? LAST_PTR : (wr_pos_reg - PTR_BITS'(1));
    assign rd_ptr_dec   = (rd_ptr_reg == '0) ? LAST_PTR : (rd_ptr_reg - PTR_BITS'(1));
    assign wr_pos_inc   = (wr_pos_reg == LAST_PTR) ? '0 : (wr_pos_reg + PTR_BITS'(1));

    // History write: at once for an item without result, after the search otherwise.
    assign out_free   = !m_tvalid_reg || m_tready;
    assign load_out   = (state_reg == S_DONE) && out_free;
    assign hist_we    = (in_accept && !in_produce) || load_out;
    assign hist_wdata = (state_reg == S_IDLE) ? s_tdata[HIST_BITS-1:0] : self_reg;

    assign issue_last = (state_reg == S_SCAN) && (axis_reg == nts_pkg::AXIS_Z)
                     && (cand_reg == limit_reg);
    assign ins_last   = cand_valid && (ins_off_reg == limit_reg);

    // Root launches: the first on entry to the root phase, the next two after finished roots.
    assign root_first = (state_next == S_ROOT) && (state_reg != S_ROOT);
    assign root_more  = (state_reg == S_ROOT) && sqrt_done && (root_idx_reg != LAST_ROOT);

    // Axis counter for the issue side.
    always_comb begin
        unique case (axis_reg)
            nts_pkg::AXIS_X: axis_next = nts_pkg::AXIS_Y;
            nts_pkg::AXIS_Y: axis_next = nts_pkg::AXIS_Z;
            default:         axis_next = nts_pkg::AXIS_X;
        endcase
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept && in_produce) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (issue_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (ins_last) begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT: begin
                if (sqrt_done && (root_idx_reg == LAST_ROOT)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            max_offset_reg <= nts_pkg::MAX_OFFSET_RESET;
            atoms_seen_reg <= '0;
            wr_pos_reg     <= '0;
            rd_ptr_reg     <= '0;
            limit_reg      <= '0;
            cand_reg       <= '0;
            axis_reg       <= nts_pkg::AXIS_X;
            ins_off_reg    <= '0;
            rd_tag_reg     <= '0;
            best_valid_reg <= '0;
            root_idx_reg   <= '0;
            root_go_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                max_offset_reg <= cfg_wr_data;
            end

            if (in_accept) begin
                atoms_seen_reg <= (in_idx == nts_pkg::ATOMS_SAT) ? nts_pkg::ATOMS_SAT
                                                                 : (in_idx + OFF_BITS'(1));
                limit_reg      <= in_limit;
                rd_ptr_reg     <= rd_ptr_start;
                cand_reg       <= OFF_BITS'(1);
                axis_reg       <= nts_pkg::AXIS_X;
                ins_off_reg    <= OFF_BITS'(1);
                best_valid_reg <= '0;
            end

            if (hist_we) begin
                wr_pos_reg <= wr_pos_inc;
            end

            // Issue one axis of one candidate per cycle.
            if (state_reg == S_SCAN) begin
                axis_reg <= axis_next;
                if (axis_reg == nts_pkg::AXIS_Z) begin
                    cand_reg   <= cand_reg + OFF_BITS'(1);
                    rd_ptr_reg <= rd_ptr_dec;
                end
            end
            rd_tag_reg.valid <= (state_reg == S_SCAN);
            rd_tag_reg.axis  <= axis_reg;

            // Insert a finished distance into the sorted list of three.
            if (cand_valid) begin
                ins_off_reg <= ins_off_reg + OFF_BITS'(1);
                if (lt[0]) begin
                    best_valid_reg <= {best_valid_reg[1], best_valid_reg[0], 1'b1};
                end else if (lt[1]) begin
                    best_valid_reg <= {best_valid_reg[1], 1'b1, best_valid_reg[0]};
                end else if (lt[2]) begin
                    best_valid_reg[2] <= 1'b1;
                end
            end

            // Launch the three roots one after the other.
            root_go_reg <= root_first || root_more;
            if (root_first) begin
                root_idx_reg <= '0;
            end else if (root_more) begin
                root_idx_reg <= root_idx_reg + 2'd1;
            end

            // Output register.
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // A missing entry ranks behind every real distance.
    always_comb begin
        for (int i = 0; i < nts_pkg::NEAR_COUNT; i++) begin
            lt[i] = !best_valid_reg[i] || (cand_dist < best_dist_reg[i]);
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            self_reg <= s_tdata[HIST_BITS-1:0];
        end

        if (cand_valid) begin
            if (lt[0]) begin
                best_dist_reg[2] <= best_dist_reg[1];
                best_off_reg[2]  <= best_off_reg[1];
                best_dist_reg[1] <= best_dist_reg[0];
                best_off_reg[1]  <= best_off_reg[0];
                best_dist_reg[0] <= cand_dist;
                best_off_reg[0]  <= ins_off_reg;
            end else if (lt[1]) begin
                best_dist_reg[2] <= best_dist_reg[1];
                best_off_reg[2]  <= best_off_reg[1];
                best_dist_reg[1] <= cand_dist;
                best_off_reg[1]  <= ins_off_reg;
            end else if (lt[2]) begin
                best_dist_reg[2] <= cand_dist;
                best_off_reg[2]  <= ins_off_reg;
            end
        end

        if ((state_reg == S_ROOT) && sqrt_done) begin
            root_reg[root_idx_reg] <= sqrt_result;
        end

        if (load_out) begin
            m_tdata_reg <= {nts_pkg::M_PAD_BITS'(0),
                            DIST_BITS'(root_reg[2]),
                            DIST_BITS'(root_reg[1]),
                            DIST_BITS'(root_reg[0]),
                            best_off_reg[2],
                            best_off_reg[1],
                            best_off_reg[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Coordinate history of the current segment.
    nts_ram #(
        .WIDTH (HIST_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (hist_we),
        .wr_addr (wr_pos_reg),
        .wr_data (hist_wdata),
        .rd_addr (rd_ptr_reg),
        .rd_data (hist_rdata)
    );

    // Shared squared-distance unit.
    nts_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tag_in      (rd_tag_reg),
        .self_coords (self_reg),
        .hist_word   (hist_rdata),
        .dist_valid  (cand_valid),
        .sq_dist     (cand_dist)
    );

    // Rounded square root, shared by the three distances.
    nts_sqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_go_reg),
        .operand (best_dist_reg[root_idx_reg]),
        .busy    (sqrt_busy),
        .done    (sqrt_done),
        .result  (sqrt_result)
    );

    // The root unit is only started when it is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        root_go_reg |-> !sqrt_busy)
        else $error("square root started while busy");

    // The search fills all three places before the roots are taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROOT) && (root_idx_reg == 2'd0) && root_go_reg
        |-> (best_valid_reg == 3'b111))
        else $error("fewer than three candidates at root phase");

    // The list of best distances stays sorted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (best_valid_reg == 3'b111)
        |-> (best_dist_reg[0] <= best_dist_reg[1]) && (best_dist_reg[1] <= best_dist_reg[2]))
        else $error("best distance list out of order");

    // No more distances arrive than candidates were issued.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cand_valid |-> (ins_off_reg <= limit_reg)
                    && ((state_reg == S_SCAN) || (state_reg == S_DRAIN)))
        else $error("distance arrived outside the search");

    // A result is loaded only into a free output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_tvalid_reg || m_tready))
        else $error("pending result overwritten");

endmodule

// ===== sim/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for the nearest-three predecessor selector. Atoms are
// streamed in with random gaps and segment breaks. An in-bench neighbor
// search predicts each result item, and each item the block returns is
// checked field by field against the oldest prediction. The max_offset
// register is rewritten between phases while the block is idle. One long
// receiver hold-off backs the block up so that it stalls its input.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    localparam int COORD_W      = nts_pkg::COORD_BITS_DEF;
    localparam int S_DATA_W     = ((3 * COORD_W + 7) / 8) * 8;
    localparam int S_PAD_W      = S_DATA_W - 3 * COORD_W;
    localparam int GAP_MAX      = 15;
    localparam int HOLD_AFTER   = 120;     // results seen before the long hold-off
    localparam int HOLD_CYCLES  = 1500;
    localparam int WATCHDOG_MAX = 20000;   // quiet cycles before giving up
    localparam int CFG_SETTLE   = 20;      // atoms without a result finish on acceptance
    localparam int DRAIN_CYCLES = 400;     // above one full 64-deep search
    localparam int PHASE_ATOMS  = 125;
    localparam int LONG_SEGMENT = 270;     // long enough to saturate the atom index
    localparam int CLUSTER_SPAN = 3;

    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_ZERO = '0;
    localparam logic signed [COORD_W-1:0] COORD_NEG1 = '1;
    localparam logic signed [COORD_W-1:0] BITS_ODD  = 30'h2AAAAAAA;
    localparam logic signed [COORD_W-1:0] BITS_EVEN = 30'h15555555;

    // How the coordinates of one segment are spread.
    typedef enum logic [1:0] {
        SPREAD_WIDE,
        SPREAD_CLUSTER,
        SPREAD_CORNER
    } spread_t;

    // ------------------------------------------------------------------------
    // Neighbor predictor and store of expected result items.
    // ------------------------------------------------------------------------
    class neighbor_board;
        localparam int DEPTH = nts_pkg::WINDOW_DEPTH_DEF;

        // Field order mirrors m_tdata: near_offset_a sits in the lowest bits.
        typedef struct packed {
            logic [nts_pkg::DIST_BITS-1:0] dist_c;
            logic [nts_pkg::DIST_BITS-1:0] dist_b;
            logic [nts_pkg::DIST_BITS-1:0] dist_a;
            logic [nts_pkg::OFF_BITS-1:0]  off_c;
            logic [nts_pkg::OFF_BITS-1:0]  off_b;
            logic [nts_pkg::OFF_BITS-1:0]  off_a;
        } near_set_t;

        longint          hist_x [DEPTH];
        longint          hist_y [DEPTH];
        longint          hist_z [DEPTH];
        int unsigned     atom_index;
        int unsigned     ring_pos;
        logic [nts_pkg::OFF_BITS-1:0] search_cfg;
        near_set_t       pending_sets [$];
        int              errors;
        int              checked;

        function new();
            atom_index = 0;
            ring_pos   = 0;
            search_cfg = nts_pkg::MAX_OFFSET_RESET;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_max_offset(logic [nts_pkg::OFF_BITS-1:0] value);
            search_cfg = value;
        endfunction

        function int pending();
            return pending_sets.size();
        endfunction

        // Floor root bit by bit, then round up when n exceeds r*r + r.
        function longint unsigned rounded_root(longint unsigned n);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= n) begin
                    r = t;
                end
            end
            if (n - r * r > r) begin
                r = r + 1;
            end
            return r;
        endfunction

        // Takes one accepted atom; queues a prediction for atoms of index 3 on.
        function void note_atom(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                logic signed [COORD_W-1:0] z, logic first_flag);
            longint          cx, cy, cz;
            longint          dx, dy, dz;
            longint unsigned sq;
            longint unsigned best_sq [nts_pkg::NEAR_COUNT];
            int unsigned     best_off [nts_pkg::NEAR_COUNT];
            int unsigned     found, span, slot, pos;
            near_set_t       ns;
            cx = x;
            cy = y;
            cz = z;
            if (first_flag) begin
                atom_index = 0;
            end
            if (atom_index >= nts_pkg::NEAR_COUNT) begin
                span = (search_cfg < nts_pkg::MIN_SEARCH) ? nts_pkg::MIN_SEARCH : search_cfg;
                if (span > DEPTH) begin
                    span = DEPTH;
                end
                if (span > atom_index) begin
                    span = atom_index;
                end
                found = 0;
                for (int j = 1; j <= span; j++) begin
                    slot = (ring_pos + DEPTH - j) % DEPTH;
                    dx = cx - hist_x[slot];
                    dy = cy - hist_y[slot];
                    dz = cz - hist_z[slot];
                    sq = dx * dx + dy * dy + dz * dz;
                    // Insert by strict less-than, so an equal distance keeps
                    // the nearer offset ahead of it.
                    pos = found;
                    while (pos > 0 && sq < best_sq[pos-1]) begin
                        if (pos < nts_pkg::NEAR_COUNT) begin
                            best_sq[pos]  = best_sq[pos-1];
                            best_off[pos] = best_off[pos-1];
                        end
                        pos--;
                    end
                    if (pos < nts_pkg::NEAR_COUNT) begin
                        best_sq[pos]  = sq;
                        best_off[pos] = j;
                    end
                    if (found < nts_pkg::NEAR_COUNT) begin
                        found++;
                    end
                end
                ns.off_a  = nts_pkg::OFF_BITS'(best_off[0]);
                ns.off_b  = nts_pkg::OFF_BITS'(best_off[1]);
                ns.off_c  = nts_pkg::OFF_BITS'(best_off[2]);
                ns.dist_a = nts_pkg::DIST_BITS'(rounded_root(best_sq[0]));
                ns.dist_b = nts_pkg::DIST_BITS'(rounded_root(best_sq[1]));
                ns.dist_c = nts_pkg::DIST_BITS'(rounded_root(best_sq[2]));
                pending_sets.insert(pending_sets.size(), ns);
            end
            hist_x[ring_pos] = cx;
            hist_y[ring_pos] = cy;
            hist_z[ring_pos] = cz;
            ring_pos = (ring_pos + 1) % DEPTH;
            if (atom_index < nts_pkg::ATOMS_SAT) begin
                atom_index++;
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, longint unsigned got, longint unsigned want);
            if (got != want) begin
                report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                          checked, name, got, want));
            end
        endtask

        // Checks one accepted result item against the oldest prediction.
        task check_result(logic [nts_pkg::M_DATA_BITS-1:0] word);
            near_set_t got, want;
            if (pending_sets.size() == 0) begin
                report_mismatch($sformatf("result with no prediction waiting: %h", word));
                return;
            end
            want = pending_sets.pop_front();
            got  = near_set_t'(word[nts_pkg::M_FIELD_BITS-1:0]);
            compare_field("near_offset_a", got.off_a, want.off_a);
            compare_field("near_offset_b", got.off_b, want.off_b);
            compare_field("near_offset_c", got.off_c, want.off_c);
            compare_field("near_dist_a", got.dist_a, want.dist_a);
            compare_field("near_dist_b", got.dist_b, want.dist_b);
            compare_field("near_dist_c", got.dist_c, want.dist_c);
            checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test.
    // ------------------------------------------------------------------------
    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [nts_pkg::OFF_BITS-1:0]    cfg_wr_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [S_DATA_W-1:0]             s_tdata;       // coord_x, coord_y, coord_z
    logic                            s_tuser;       // first_atom
    logic                            m_tvalid;
    logic                            m_tready;
    // near_offset_a, near_offset_b, near_offset_c, near_dist_a, near_dist_b, near_dist_c
    logic [nts_pkg::M_DATA_BITS-1:0] m_tdata;

    neighbor_board board = new();

    int  atoms_sent    = 0;
    int  segments_sent = 0;
    int  settings_used = 0;
    int  results_seen  = 0;
    int  quiet_cycles  = 0;
    bit  tx_burst      = 1'b0;
    bit  rx_burst      = 1'b0;
    bit  hold_done     = 1'b0;

    always #4 aclk = ~aclk;

    nearest_three_predecessor_select dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Watchdog: too long without any item moving on either side ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("Timeout: no item accepted for %0d cycles.", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic logic signed [COORD_W-1:0] pick_coord(spread_t mode,
                                                             logic signed [COORD_W-1:0] center);
        case (mode)
            SPREAD_CLUSTER: begin
                return COORD_W'(int'(center) + int'($urandom_range(0, 2 * CLUSTER_SPAN))
                                - CLUSTER_SPAN);
            end
            SPREAD_CORNER: begin
                case ($urandom_range(0, 3))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return COORD_ZERO;
                    default: return COORD_NEG1;
                endcase
            end
            default: begin
                return COORD_W'($urandom);
            end
        endcase
    endfunction

    // Offers one atom after a random gap and waits until it is taken.
    task automatic send_atom(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z, logic first_flag);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{S_PAD_W{1'b0}}, z, y, x};
        s_tuser  <= first_flag;
        do @(posedge aclk); while (!s_tready);
        board.note_atom(x, y, z, first_flag);
        atoms_sent++;
        if (first_flag) begin
            segments_sent++;
        end
    endtask

    task automatic run_segment(int length, spread_t mode, logic lead_flag);
        logic signed [COORD_W-1:0] center;
        center = COORD_W'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
        for (int i = 0; i < length; i++) begin
            send_atom(pick_coord(mode, center), pick_coord(mode, center),
                      pick_coord(mode, center), (i == 0) ? lead_flag : 1'b0);
        end
    endtask

    // Random segments: mostly well-formed runs, with short runs that give no
    // result and the odd run that simply continues the previous segment.
    task automatic run_phase(int count);
        int      done_atoms;
        int      len;
        int      pick;
        spread_t mode;
        done_atoms = 0;
        while (done_atoms < count) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                len = $urandom_range(60, 200);
            end else if (pick < 4) begin
                len = $urandom_range(1, 3);
            end else begin
                len = $urandom_range(4, 40);
            end
            if (len > count - done_atoms) begin
                len = count - done_atoms;
            end
            pick = $urandom_range(0, 9);
            mode = (pick < 4) ? SPREAD_CLUSTER : (pick < 8) ? SPREAD_WIDE : SPREAD_CORNER;
            tx_burst = ($urandom_range(0, 3) == 0);
            run_segment(len, mode, ($urandom_range(0, 7) != 0));
            done_atoms += len;
        end
    endtask

    // Stops offering and waits until every predicted item has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (CFG_SETTLE) @(posedge aclk);
    endtask

    task automatic write_max_offset(logic [nts_pkg::OFF_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.set_max_offset(value);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, one long hold-off to back the block up.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!hold_done && results_seen == HOLD_AFTER) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                stall = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_result(m_tdata);
            results_seen++;
            if (results_seen % 64 == 0) begin
                rx_burst = ($urandom_range(0, 2) == 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [nts_pkg::OFF_BITS-1:0] settings [10];
        settings = '{8'd3, 8'd255, 8'd0, 8'd1, 8'd2, 8'd64, 8'd5, 8'd200, 8'd63, 8'd0};
        settings[9] = nts_pkg::OFF_BITS'($urandom_range(3, 255));

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed atoms at the reset setting. The stream opens without a
        // segment flag, so the first atom starts a segment implicitly.
        send_atom(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_atom(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_atom(COORD_ZERO, COORD_ZERO, COORD_ZERO, 1'b0);
        send_atom(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        send_atom(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        send_atom(COORD_ZERO, COORD_ZERO, COORD_ZERO, 1'b0);
        send_atom(COORD_NEG1, COORD_NEG1, COORD_NEG1, 1'b0);
        send_atom(30'sd1, COORD_ZERO, COORD_ZERO, 1'b0);
        send_atom(COORD_ZERO, 30'sd1, COORD_ZERO, 1'b0);
        send_atom(COORD_ZERO, COORD_ZERO, 30'sd1, 1'b0);
        // A fresh segment in the middle of the stream, with equal distances.
        send_atom(30'sd5, 30'sd5, 30'sd5, 1'b1);
        send_atom(30'sd5, 30'sd5, 30'sd6, 1'b0);
        send_atom(30'sd5, 30'sd6, 30'sd5, 1'b0);
        send_atom(30'sd6, 30'sd5, 30'sd5, 1'b0);
        send_atom(30'sd5, 30'sd5, 30'sd5, 1'b0);
        // A segment too short to give a result, then alternating bit patterns.
        send_atom(COORD_MAX, COORD_ZERO, COORD_MIN, 1'b1);
        send_atom(COORD_ZERO, COORD_ZERO, COORD_ZERO, 1'b0);
        send_atom(COORD_ZERO, COORD_ZERO, COORD_ZERO, 1'b1);
        send_atom(BITS_ODD, BITS_EVEN, BITS_ODD, 1'b0);
        send_atom(BITS_EVEN, BITS_ODD, BITS_EVEN, 1'b0);
        send_atom(BITS_ODD, BITS_ODD, BITS_ODD, 1'b0);
        send_atom(BITS_EVEN, BITS_EVEN, BITS_EVEN, 1'b0);
        settle();

        // Random phases, each under its own search depth.
        foreach (settings[i]) begin
            write_max_offset(settings[i]);
            if (settings[i] == 8'd255) begin
                tx_burst = 1'b0;
                run_segment(LONG_SEGMENT, SPREAD_WIDE, 1'b1);
            end
            run_phase(PHASE_ATOMS);
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d atoms in %0d flagged segments under %0d max_offset settings.",
                 atoms_sent, segments_sent, settings_used);
        $display("Checked %0d neighbor results with %0d mismatches.",
                 board.checked, board.errors);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
